// ===== hw/rtl/hfl_pkg.sv =====
// hfl_pkg: shared types and constants for the hex float literal converter.
// No dependencies; every other file in hw/rtl but hfl_if.sv imports it.
package hfl_pkg;

    localparam int CNT_W       = 11;
    localparam int MANT_W      = 64;
    localparam int E_W         = 16;
    localparam int EXP_CLAMP_W = 13;
    localparam int EXP_CLAMP_MAX = 8191;

    localparam logic [CNT_W-1:0] CNT_MAX      = 11'd2047;
    localparam logic [CNT_W-1:0] MANT_BITS    = 11'd64;
    localparam logic [CNT_W-1:0] USED_STICKY  = 11'd60;

    localparam logic signed [E_W-1:0] E_BIAS  = 16'sd1023;
    localparam logic signed [E_W-1:0] E_INF   = 16'sd2047;
    localparam logic signed [E_W-1:0] E_FLUSH = -16'sd52;
    localparam logic signed [E_W-1:0] E_ONE   = 16'sd1;
    localparam logic signed [E_W-1:0] E_SUB_SHIFT = 16'sd9;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

    // ASCII codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_P_UP  = 8'h50;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_P_LO  = 8'h70;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    // Literal snapshot taken on the last character
    typedef struct packed {
        logic                          bad;
        logic                          sign;
        logic [MANT_W-1:0]             mant;
        logic [CNT_W-1:0]              frac_cnt;
        logic [CNT_W-1:0]              digit_cnt;
        logic                          used_gt60;
        logic signed [EXP_CLAMP_W:0]   exp_adj;
    } t_lit;

    // Normalized mantissa and biased exponent
    typedef struct packed {
        logic                  bad;
        logic                  sign;
        logic                  zero;
        logic signed [E_W-1:0] exp;
        logic [MANT_W-1:0]     mant;
        logic                  used_gt60;
    } t_norm;

endpackage

// ===== hw/rtl/hfl_if.sv =====
// hfl_if: stream interfaces for characters in and converted words out.
// Standalone; used by the top level and its parser and pack stages.
interface hfl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

interface hfl_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    logic        malformed;

    modport source (output valid, value_bits, malformed, input ready);
    modport sink   (input valid, value_bits, malformed, output ready);
endinterface

// ===== hw/rtl/hfl_char_parser.sv =====
// hfl_char_parser: input register and per-character literal state; emits a
// snapshot word on the last character. Depends on hfl_pkg and hfl_if.
module hfl_char_parser #(
    parameter int MAX_CHARS     = 256,
    parameter int EXP_SAT_WIDTH = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hfl_char_if.sink      i_char,
    output logic          o_lit_valid,
    input  logic          i_lit_ready,
    output hfl_pkg::t_lit o_lit
);
    import hfl_pkg::*;

    localparam int PW = $clog2(MAX_CHARS + 1);
    localparam int XW = EXP_SAT_WIDTH + 4;
    localparam logic [EXP_SAT_WIDTH-1:0] EXP_LIM = {EXP_SAT_WIDTH{1'b1}};

    localparam logic [1:0] PFX_SIGN = 2'd0;
    localparam logic [1:0] PFX_ZERO = 2'd1;
    localparam logic [1:0] PFX_X    = 2'd2;
    localparam logic [1:0] PFX_BODY = 2'd3;

    function automatic logic [CNT_W-1:0] sat_add4(input logic [CNT_W-1:0] v);
        logic [CNT_W:0] s;
        s = {1'b0, v} + (CNT_W+1)'(4);
        return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    logic                     r_sign,      n_sign;
    logic                     r_point,     n_point;
    logic                     r_in_exp,    n_in_exp;
    logic                     r_exp_neg,   n_exp_neg;
    logic [EXP_SAT_WIDTH-1:0] r_exp_mag,   n_exp_mag;
    logic [MANT_W-1:0]        r_mant,      n_mant;
    logic [CNT_W-1:0]         r_dcnt,      n_dcnt;
    logic [CNT_W-1:0]         r_used,      n_used;
    logic [CNT_W-1:0]         r_frac,      n_frac;
    logic [PW-1:0]            r_pos,       n_pos;
    logic                     r_err,       n_err;
    logic [1:0]               r_pfx,       n_pfx;
    logic                     r_dig_seen,  n_dig_seen;
    logic                     r_esign_seen, n_esign_seen;
    logic                     r_edig_seen, n_edig_seen;

    logic  r_lit_valid;
    t_lit  r_lit, n_lit;

    logic  adv;
    logic  is_dec, is_up, is_lo, is_hex;
    logic [3:0] dval;
    logic [XW-1:0] exp_wide, exp_calc;
    logic [EXP_SAT_WIDTH-1:0] exp_next;
    logic [EXP_CLAMP_W-1:0]   mag_cl;

    assign adv          = r_in_valid && (!r_in_last || !r_lit_valid || i_lit_ready);
    assign i_char.ready = !r_in_valid || adv;
    assign o_lit_valid  = r_lit_valid;
    assign o_lit        = r_lit;

    assign is_dec = (r_in_char >= CH_0) && (r_in_char <= CH_9);
    assign is_up  = (r_in_char >= CH_A_UP) && (r_in_char <= CH_F_UP);
    assign is_lo  = (r_in_char >= CH_A_LO) && (r_in_char <= CH_F_LO);
    assign is_hex = is_dec || is_up || is_lo;

    always_comb begin
        if (is_dec) begin
            dval = 4'(r_in_char - CH_0);
        end else if (is_up) begin
            dval = 4'(r_in_char - CH_A_UP + 8'd10);
        end else begin
            dval = 4'(r_in_char - CH_A_LO + 8'd10);
        end
    end

    // exponent * 10 + digit, saturating
    assign exp_wide = XW'(r_exp_mag);
    assign exp_calc = (exp_wide << 3) + (exp_wide << 1) + XW'(dval);
    assign exp_next = (exp_calc > XW'(EXP_LIM)) ? EXP_LIM : exp_calc[EXP_SAT_WIDTH-1:0];

    always_comb begin
        n_sign       = r_sign;
        n_point      = r_point;
        n_in_exp     = r_in_exp;
        n_exp_neg    = r_exp_neg;
        n_exp_mag    = r_exp_mag;
        n_mant       = r_mant;
        n_dcnt       = r_dcnt;
        n_used       = r_used;
        n_frac       = r_frac;
        n_pos        = r_pos;
        n_err        = r_err;
        n_pfx        = r_pfx;
        n_dig_seen   = r_dig_seen;
        n_esign_seen = r_esign_seen;
        n_edig_seen  = r_edig_seen;
        n_lit        = r_lit;
        mag_cl       = '0;

        if (adv) begin
            if (r_pos >= PW'(MAX_CHARS)) begin
                n_err = 1'b1;
            end else begin
                n_pos = r_pos + PW'(1);
                if (!r_err) begin
                    if (r_in_exp) begin
                        if ((r_in_char == CH_PLUS || r_in_char == CH_MINUS) &&
                            !r_esign_seen && !r_edig_seen) begin
                            n_esign_seen = 1'b1;
                            n_exp_neg    = (r_in_char == CH_MINUS);
                        end else if (is_dec) begin
                            n_exp_mag   = exp_next;
                            n_edig_seen = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end else begin
                        unique case (r_pfx)
                            PFX_SIGN: begin
                                if (r_in_char == CH_PLUS || r_in_char == CH_MINUS) begin
                                    n_sign = (r_in_char == CH_MINUS);
                                    n_pfx  = PFX_ZERO;
                                end else if (r_in_char == CH_0) begin
                                    n_pfx = PFX_X;
                                end else begin
                                    n_err = 1'b1;
                                end
                            end
                            PFX_ZERO: begin
                                if (r_in_char == CH_0) n_pfx = PFX_X;
                                else n_err = 1'b1;
                            end
                            PFX_X: begin
                                if (r_in_char == CH_X_LO || r_in_char == CH_X_UP) n_pfx = PFX_BODY;
                                else n_err = 1'b1;
                            end
                            PFX_BODY: begin
                                if (r_in_char == CH_POINT) begin
                                    if (r_point) n_err = 1'b1;
                                    else n_point = 1'b1;
                                end else if (r_in_char == CH_P_LO || r_in_char == CH_P_UP) begin
                                    n_in_exp = 1'b1;
                                end else if (!is_hex) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_dig_seen = 1'b1;
                                    if (r_point) n_frac = sat_add4(r_frac);
                                    // leading zeros do not count as digit bits
                                    if (!(dval == 4'd0 && r_mant == '0)) begin
                                        n_dcnt = sat_add4(r_dcnt);
                                        if (dval != 4'd0) n_used = n_dcnt;
                                        if (n_dcnt <= MANT_BITS) n_mant = {r_mant[MANT_W-5:0], dval};
                                    end
                                end
                            end
                        endcase
                    end
                end
            end

            if (r_in_last) begin
                mag_cl = (n_exp_mag > EXP_SAT_WIDTH'(EXP_CLAMP_MAX)) ?
                         {EXP_CLAMP_W{1'b1}} : n_exp_mag[EXP_CLAMP_W-1:0];
                n_lit.bad       = n_err || !n_in_exp || !n_dig_seen ||
                                  (n_esign_seen && !n_edig_seen);
                n_lit.sign      = n_sign;
                n_lit.mant      = n_mant;
                n_lit.frac_cnt  = n_frac;
                n_lit.digit_cnt = n_dcnt;
                n_lit.used_gt60 = (n_used > USED_STICKY);
                n_lit.exp_adj   = n_exp_neg ? -$signed({1'b0, mag_cl}) : $signed({1'b0, mag_cl});

                n_sign       = 1'b0;
                n_point      = 1'b0;
                n_in_exp     = 1'b0;
                n_exp_neg    = 1'b0;
                n_exp_mag    = '0;
                n_mant       = '0;
                n_dcnt       = '0;
                n_used       = '0;
                n_frac       = '0;
                n_pos        = '0;
                n_err        = 1'b0;
                n_pfx        = PFX_SIGN;
                n_dig_seen   = 1'b0;
                n_esign_seen = 1'b0;
                n_edig_seen  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_lit_valid  <= 1'b0;
            r_sign       <= 1'b0;
            r_point      <= 1'b0;
            r_in_exp     <= 1'b0;
            r_exp_neg    <= 1'b0;
            r_exp_mag    <= '0;
            r_mant       <= '0;
            r_dcnt       <= '0;
            r_used       <= '0;
            r_frac       <= '0;
            r_pos        <= '0;
            r_err        <= 1'b0;
            r_pfx        <= PFX_SIGN;
            r_dig_seen   <= 1'b0;
            r_esign_seen <= 1'b0;
            r_edig_seen  <= 1'b0;
        end else begin
            if (i_char.ready) r_in_valid <= i_char.valid;
            if (adv && r_in_last) r_lit_valid <= 1'b1;
            else if (i_lit_ready) r_lit_valid <= 1'b0;
            r_sign       <= n_sign;
            r_point      <= n_point;
            r_in_exp     <= n_in_exp;
            r_exp_neg    <= n_exp_neg;
            r_exp_mag    <= n_exp_mag;
            r_mant       <= n_mant;
            r_dcnt       <= n_dcnt;
            r_used       <= n_used;
            r_frac       <= n_frac;
            r_pos        <= n_pos;
            r_err        <= n_err;
            r_pfx        <= n_pfx;
            r_dig_seen   <= n_dig_seen;
            r_esign_seen <= n_esign_seen;
            r_edig_seen  <= n_edig_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.char_code;
            r_in_last <= i_char.last;
        end
        r_lit <= n_lit;
    end

endmodule

// ===== hw/rtl/hfl_normalize.sv =====
// hfl_normalize: leading-one search, binary exponent and mantissa alignment
// to bit 60, registered. Depends on hfl_pkg.
module hfl_normalize (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hfl_pkg::t_lit  i_lit,
    output logic           o_valid,
    input  logic           i_ready,
    output hfl_pkg::t_norm o_norm
);
    import hfl_pkg::*;

    logic             r_valid;
    t_norm            r_norm, n_norm;
    logic [5:0]       top;
    logic [CNT_W-1:0] extra;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_norm  = r_norm;

    always_comb begin
        top = '0;
        for (int i = 0; i < MANT_W; i++) begin
            if (i_lit.mant[i]) top = 6'(i);
        end
    end

    // digits dropped past 64 bits still scale the value
    assign extra = (i_lit.digit_cnt > MANT_BITS) ? (i_lit.digit_cnt - MANT_BITS) : '0;

    always_comb begin
        n_norm.bad       = i_lit.bad;
        n_norm.sign      = i_lit.sign;
        n_norm.zero      = (i_lit.mant == '0);
        n_norm.used_gt60 = i_lit.used_gt60;
        n_norm.exp       = E_BIAS + $signed({10'd0, top}) - $signed({5'd0, i_lit.frac_cnt})
                           + $signed({5'd0, extra}) + E_W'(i_lit.exp_adj);
        if (top <= 6'd60) n_norm.mant = i_lit.mant << (6'd60 - top);
        else n_norm.mant = i_lit.mant >> (top - 6'd60);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_norm <= n_norm;
    end

endmodule

// ===== hw/rtl/hfl_round_pack.sv =====
// hfl_round_pack: round to nearest even, subnormal shift, flush and
// saturation, packing into the binary64 output register. Depends on hfl_pkg, hfl_if.
module hfl_round_pack (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hfl_pkg::t_norm i_norm,
    hfl_result_if.source   o_result
);
    import hfl_pkg::*;

    logic        r_valid;
    logic [63:0] r_bits, n_bits;
    logic        r_mal;

    logic signed [E_W-1:0] sh_w, em1;
    logic [5:0]            sh;
    logic [63:0]           mask, q, sign_word;
    logic                  rb, rm, eb;

    assign o_ready           = !r_valid || o_result.ready;
    assign o_result.valid    = r_valid;
    assign o_result.value_bits = r_bits;
    assign o_result.malformed  = r_mal;

    always_comb begin
        sh_w = E_SUB_SHIFT - i_norm.exp;
        em1  = i_norm.exp - E_ONE;
        // subnormals shift further by one bit per step below exponent one
        if (i_norm.exp < E_ONE) sh = sh_w[5:0];
        else sh = 6'd8;
        mask = (64'd1 << (sh - 6'd1)) - 64'd1;
        rb   = i_norm.mant[sh - 6'd1];
        rm   = |(i_norm.mant & mask);
        eb   = i_norm.mant[sh];
        q    = i_norm.mant >> sh;
        if (rb && (rm || i_norm.used_gt60 || eb)) q = q + 64'd1;
        sign_word = {i_norm.sign, 63'd0};

        priority if (i_norm.bad) begin
            n_bits = '0;
        end else if (i_norm.zero || i_norm.exp < E_FLUSH) begin
            n_bits = sign_word;
        end else if (i_norm.exp >= E_INF) begin
            n_bits = sign_word | {1'b0, EXP_ALL_ONES, 52'd0};
        end else if (i_norm.exp >= E_ONE) begin
            // rounding carry runs into the exponent field
            n_bits = sign_word | ({1'b0, em1[10:0], 52'd0} + q);
        end else begin
            n_bits = sign_word | q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bits <= n_bits;
            r_mal  <= i_norm.bad;
        end
    end

endmodule

// ===== hw/rtl/hex_float_literal_to_double_unit.sv =====
// Path: the input register, the literal snapshot, normalize and output registers.
// Throughput: one character per cycle unless a last character meets a full
// snapshot, set by the parser state update; words wait in the output register.
// Reset: synchronous, active low; clears the literal state and all valid flags.
// Depends on hfl_pkg, hfl_if, hfl_char_parser, hfl_normalize, hfl_round_pack.
module hex_float_literal_to_double_unit #(
    parameter int MAX_CHARS     = 256,
    parameter int EXP_SAT_WIDTH = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hfl_char_if.sink     i_char,
    hfl_result_if.source o_result
);
    import hfl_pkg::*;

    logic  lit_valid, lit_ready;
    t_lit  lit;
    logic  norm_valid, norm_ready;
    t_norm norm;

    hfl_char_parser #(
        .MAX_CHARS     (MAX_CHARS),
        .EXP_SAT_WIDTH (EXP_SAT_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_char),
        .o_lit_valid (lit_valid),
        .i_lit_ready (lit_ready),
        .o_lit       (lit)
    );

    hfl_normalize u_normalize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lit_valid),
        .o_ready (lit_ready),
        .i_lit   (lit),
        .o_valid (norm_valid),
        .i_ready (norm_ready),
        .o_norm  (norm)
    );

    hfl_round_pack u_round_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (norm_valid),
        .o_ready  (norm_ready),
        .i_norm   (norm),
        .o_result (o_result)
    );

endmodule

// ===== hw/rtl/hfl_checker.sv =====
// hfl_checker: port-level assertions for the converter, bound to the top level.
// Depends on hfl_pkg and hex_float_literal_to_double_unit.
module hfl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_bits,
    input logic        i_out_malformed
);
    import hfl_pkg::*;

    logic       in_done, out_done;
    logic [3:0] r_pending;

    assign in_done  = i_in_valid && i_in_ready && i_in_last;
    assign out_done = i_out_valid && i_out_ready;

    // literals whose word has not yet been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {3'd0, in_done} - {3'd0, out_done};
        end
    end

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 4'd0)
        else $error("word out with no literal pending");

    a_malformed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_malformed |-> i_out_bits == 64'd0)
        else $error("malformed word carries nonzero bits");

    a_no_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_malformed && i_out_bits[62:52] == EXP_ALL_ONES
        |-> i_out_bits[51:0] == 52'd0)
        else $error("NaN pattern produced");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_bits) &&
        $stable(i_out_malformed))
        else $error("stalled word changed");

endmodule

bind hex_float_literal_to_double_unit hfl_checker u_hfl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_char.valid),
    .i_in_ready      (i_char.ready),
    .i_in_last       (i_char.last),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_out_bits      (o_result.value_bits),
    .i_out_malformed (o_result.malformed)
);
